// ===== src/pqcr_pkg.sv =====
// ----------------------------------------------------------------------------
// pqcr_pkg
// Shared types, constants and helpers for the PCM quantizer / channel remapper.
// ----------------------------------------------------------------------------
package pqcr_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
    localparam int SUM_W        = 32 + CH_W;
    localparam int DIV_W        = SUM_W;

    localparam logic [2:0] FMT_F32 = 3'd0;
    localparam logic [2:0] FMT_I16 = 3'd1;
    localparam logic [2:0] FMT_I24 = 3'd2;
    localparam logic [2:0] FMT_I32 = 3'd3;

    localparam logic [1:0] REG_SRC = 2'd0;
    localparam logic [1:0] REG_DST = 2'd1;
    localparam logic [1:0] REG_FMT = 2'd2;

    localparam logic [31:0] K_I16 = 32'd32767;
    localparam logic [31:0] K_I24 = 32'd8388607;
    localparam logic [31:0] K_I32 = 32'd2147483520;

    // Work kinds handed from front to back.
    typedef enum logic [1:0] {
        JOB_COPY,
        JOB_PASS,
        JOB_MIX
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic signed [SUM_W-1:0] value;
        logic [CNT_W-1:0]   divisor;
        logic [CH_W-1:0]    first_ch;
        logic               enc_first;
        logic [CNT_W-1:0]   last_ch;
        logic [CNT_W-1:0]   nd;
        logic [2:0]         fmt;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ENC,
        ST_EMIT
    } back_state_t;

    function automatic logic [CNT_W-1:0] eff_count(input logic [3:0] v);
        logic [CNT_W-1:0] r;
        if (v == 4'd0)
            r = CNT_W'(1);
        else if (32'(v) > MAX_CHANNELS)
            r = CNT_W'(MAX_CHANNELS);
        else
            r = CNT_W'(v);
        return r;
    endfunction

endpackage

// ===== src/pqcr_front.sv =====
// ----------------------------------------------------------------------------
// pqcr_front
// Accepts source samples, tracks frame position and mix sum, issues jobs.
// ----------------------------------------------------------------------------
module pqcr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [3:0]           src_channels,
    input  logic [3:0]           dst_channels,
    input  logic [2:0]           out_format,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [31:0]          in_sample,
    output logic                 job_valid,
    input  logic                 job_full,
    output pqcr_pkg::job_t       job
);
    import pqcr_pkg::*;

    logic [CH_W-1:0]         pos_reg, pos_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        ns, nd;
    logic [CH_W-1:0]         p;
    logic                    last_src, emit, accept;
    logic signed [SUM_W-1:0] xs, acc;

    assign ns   = eff_count(src_channels);
    assign nd   = eff_count(dst_channels);
    assign emit = (out_format <= FMT_I32);
    assign in_stall = job_full;
    assign accept   = in_valid && !job_full;
    assign xs = SUM_W'(signed'(in_sample));

    always_comb
    begin
        p = (CNT_W'(pos_reg) >= ns) ? '0 : pos_reg;
        last_src = (CNT_W'(p) + CNT_W'(1) == ns);
        acc = ((CNT_W'(pos_reg) >= ns) ? '0 : sum_reg) + xs;
        pos_next = last_src ? '0 : p + CH_W'(1);
        sum_next = (ns == CNT_W'(1) || nd != CNT_W'(1) || last_src) ? '0 : acc;
        job = '0;
        job.fmt = out_format;
        job.nd = nd;
        job.value = xs;
        job_valid = 1'b0;
        if (ns == CNT_W'(1))
        begin
            job.kind = JOB_COPY;
            job.first_ch = '0;
            job.enc_first = 1'b1;
            job.last_ch = nd - CNT_W'(1);
            job_valid = accept && emit;
        end
        else if (nd == CNT_W'(1))
        begin
            job.kind = JOB_MIX;
            job.value = acc;
            job.divisor = ns;
            job.first_ch = '0;
            job.enc_first = 1'b1;
            job.last_ch = '0;
            job_valid = accept && emit && last_src;
        end
        else
        begin
            job.kind = JOB_PASS;
            job.enc_first = (CNT_W'(p) < nd);
            job.first_ch = p;
            job.last_ch = last_src ? nd - CNT_W'(1) : CNT_W'(p);
            job_valid = accept && emit && (job.enc_first || (last_src && CNT_W'(p) < nd));
            if (!job.enc_first)
                job_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else if (cfg_we)
        begin
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end
endmodule

// ===== src/pqcr_queue.sv =====
// ----------------------------------------------------------------------------
// pqcr_queue
// Two-entry job queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module pqcr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    input  pqcr_pkg::job_t wr_job,
    output logic           full,
    output logic           rd_valid,
    input  logic           rd_take,
    output pqcr_pkg::job_t rd_job
);
    import pqcr_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_valid)
            mem_reg[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_valid)
                wp_reg <= ~wp_reg;
            if (rd_take)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_valid) - 2'(rd_take);
        end
    end
endmodule

// ===== src/pqcr_back.sv =====
// ----------------------------------------------------------------------------
// pqcr_back
// Divides mix sums, clamps, encodes and emits destination words.
// ----------------------------------------------------------------------------
module pqcr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  pqcr_pkg::job_t job,
    output logic           job_take,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [31:0]    sample_word,
    output logic [2:0]     dest_channel,
    output logic           frame_end
);
    import pqcr_pkg::*;

    back_state_t state_reg, state_next;
    job_t        job_reg;
    logic [DIV_W-1:0] quo_reg, rem_reg;
    logic [$clog2(DIV_W+1)-1:0] cnt_reg;
    logic        neg_reg;
    logic [30:0] mag_reg;
    logic [62:0] prod_reg;
    logic [31:0] word_reg;
    logic [CNT_W-1:0] ch_reg;
    logic        first_reg;

    logic signed [SUM_W-1:0] v;
    logic [DIV_W-1:0] absv;
    logic [DIV_W:0]   trial;
    logic [30:0] mag_c;
    logic [31:0] kmul;
    logic [31:0] fword;
    logic [4:0]  msb;
    logic [23:0] mant;
    logic [30:0] rem_f, half_f;
    logic [24:0] mant_r;
    logic [7:0]  ex;
    logic [31:0] q;

    assign job_take = (state_reg == ST_IDLE) && job_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (job_valid) state_next = (job.kind == JOB_MIX) ? ST_DIV : ST_MUL;
            ST_DIV:  if (cnt_reg == '0) state_next = ST_MUL;
            ST_MUL:  state_next = ST_ENC;
            ST_ENC:  state_next = ST_EMIT;
            ST_EMIT: if (!out_stall && ch_reg == job_reg.last_ch) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid    = (state_reg == ST_EMIT);
        sample_word  = (first_reg || job_reg.kind == JOB_COPY) ? word_reg : '0;
        dest_channel = 3'(ch_reg);
        frame_end    = (ch_reg == job_reg.nd - CNT_W'(1));
    end

    always_comb
    begin
        v = (state_reg == ST_DIV) ? SUM_W'(signed'(neg_reg ? -quo_reg : quo_reg)) : job_reg.value;
        absv = job.value[SUM_W-1] ? DIV_W'(-job.value) : DIV_W'(job.value);
        trial = {rem_reg, quo_reg[DIV_W-1]} - {1'b0, (DIV_W-CNT_W)'(0), job_reg.divisor};
        if (v > SUM_W'(32'sh4000_0000))
            mag_c = 31'h4000_0000;
        else if (v < -SUM_W'(32'sh4000_0000))
            mag_c = 31'h4000_0000;
        else if (v < 0)
            mag_c = 31'(-v);
        else
            mag_c = 31'(v);
        unique case (job_reg.fmt)
            FMT_I16: kmul = K_I16;
            FMT_I24: kmul = K_I24;
            default: kmul = K_I32;
        endcase
        msb = '0;
        for (int i = 0; i < 31; i++)
            if (mag_reg[i]) msb = 5'(i);
        if (msb <= 5'd23)
        begin
            mant = 24'(mag_reg << (5'd23 - msb));
            rem_f = '0;
            half_f = 31'h7fff_ffff;
        end
        else
        begin
            mant = 24'(mag_reg >> (msb - 5'd23));
            rem_f = mag_reg & ((31'd1 << (msb - 5'd23)) - 31'd1);
            half_f = 31'd1 << (msb - 5'd24);
        end
        mant_r = {1'b0, mant} +
                 25'((rem_f > half_f) || (rem_f == half_f && mant[0]));
        ex = 8'(msb) + 8'd97 + 8'(mant_r[24]);
        fword = (mag_reg == '0) ? 32'd0 :
                {neg_reg, ex, mant_r[24] ? mant_r[23:1] : mant_r[22:0]};
        q = 32'((prod_reg + 63'(1 << 29)) >> 30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                job_reg   <= job;
                ch_reg    <= CNT_W'(job.first_ch);
                first_reg <= job.enc_first;
                quo_reg   <= absv;
                rem_reg   <= '0;
                neg_reg   <= job.value[SUM_W-1];
                cnt_reg   <= ($clog2(DIV_W+1))'(DIV_W);
            end
            ST_DIV:
            begin
                if (cnt_reg != '0)
                begin
                    if (!trial[DIV_W])
                        rem_reg <= trial[DIV_W-1:0];
                    else
                        rem_reg <= {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]};
                    quo_reg <= {quo_reg[DIV_W-2:0], !trial[DIV_W]};
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else
                    job_reg.value <= v;
            end
            ST_MUL:
            begin
                mag_reg  <= mag_c;
                neg_reg  <= job_reg.value < 0;
                prod_reg <= 63'(mag_c) * 63'(kmul);
            end
            ST_ENC:
                word_reg <= (job_reg.fmt == FMT_F32) ? fword : (neg_reg ? -q : q);
            ST_EMIT:
                if (!out_stall)
                begin
                    ch_reg    <= ch_reg + CNT_W'(1);
                    first_reg <= 1'b0;
                end
            default: ;
        endcase
    end
endmodule

// ===== src/pcm_quantize_channel_remap.sv =====
// ----------------------------------------------------------------------------
// pcm_quantize_channel_remap
// Converts Q2.30 source samples into remapped, quantized destination words.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with a 32-bit sample per beat.
// Output channel: out_valid / out_stall carrying sample_word, dest_channel
// and frame_end per beat; one input beat gives zero to eight output beats.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 to 2) and restarts
// the frame; write only while idle.
// Steps: each job passes ST_MUL, ST_ENC and ST_EMIT; a mono down-mix job
// first runs the bit-serial divider in ST_DIV.
// Flow: the single back-end encoder takes a new job only once it has emitted
// all words of the last one; a two-entry job queue lets the front keep
// accepting beats meanwhile.
// Reset: frame position and mix sum clear, registers go to 2 / 2 / int16.
// A stalled receiver holds the current output beat; once the queue fills,
// in_stall rises.
// ----------------------------------------------------------------------------
module pcm_quantize_channel_remap (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sample_word,
    output logic [2:0]  dest_channel,
    output logic        frame_end
);
    import pqcr_pkg::*;

    logic [3:0] src_reg, dst_reg;
    logic [2:0] fmt_reg;
    logic       f_valid, q_full, q_valid, q_take;
    logic       cfg_restart;
    job_t       f_job, q_job;

    assign cfg_restart = cfg_we && (cfg_index <= REG_FMT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= 4'd2;
            dst_reg <= 4'd2;
            fmt_reg <= FMT_I16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SRC: src_reg <= cfg_data;
                REG_DST: dst_reg <= cfg_data;
                REG_FMT: fmt_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    pqcr_front u_front (
        .clk, .rst_n, .cfg_we(cfg_restart),
        .src_channels(src_reg), .dst_channels(dst_reg), .out_format(fmt_reg),
        .in_valid, .in_stall, .in_sample(sample),
        .job_valid(f_valid), .job_full(q_full), .job(f_job)
    );

    pqcr_queue u_queue (
        .clk, .rst_n, .wr_valid(f_valid), .wr_job(f_job), .full(q_full),
        .rd_valid(q_valid), .rd_take(q_take), .rd_job(q_job)
    );

    pqcr_back u_back (
        .clk, .rst_n, .job_valid(q_valid), .job(q_job), .job_take(q_take),
        .out_valid, .out_stall, .sample_word, .dest_channel, .frame_end
    );
endmodule
